// ===== rtl/bra_pkg.sv =====
package bra_pkg;

    // map geometry
    localparam int MAP_BYTES = 128;
    localparam int MAP_BITS  = MAP_BYTES * 8;
    localparam int WORD_W    = 32;
    localparam int WORD_SH   = $clog2(WORD_W);
    localparam int WORDS     = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW1       = WA + 1;

    // request and result field widths
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 8;

    localparam logic [CFG_W-1:0] BYTES_RESET = CFG_W'(128);

    typedef enum logic [ACT_W-1:0] {
        ACT_ACQUIRE = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_SET     = 3'd2,
        ACT_CHECK   = 3'd3,
        ACT_CLEAR   = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOD,
        S_CHK,
        S_RESP
    } t_state;

endpackage

// ===== rtl/bitmap_run_allocator.sv =====
// bitmap_run_allocator: first-fit allocator of contiguous units over a usage bitmap
//
// request channel: i_in_valid / o_in_stall with action, index, count and bit_value;
// a transfer happens on a rising edge with valid high and stall low. stall is low
// only while the sequencer is idle, so one request is worked on at a time
// result channel: o_out_valid / i_out_stall with status, start_index and bit_read,
// held in an output register; the next request is taken while a result still waits
// config channel: i_cfg_valid / o_cfg_ready writes bytes_in_use, always ready
//
// the map lives in a 32-bit wide synchronous ram, one word per cycle through the
// read port. acquire scans words 0 .. ceil(managed/32)-1 (up to 32) until the run
// is found, then makes a read-modify-write pass over the words of the run; release
// and set make the same pass over the words of their range, check reads one word,
// and clear all and errors go straight to the response.
// reset (synchronous, active low) empties the map at once through per-word valid
// bits, so no clearing pass is needed; clear all does the same.
// when the receiver stalls, the result is held in the output register and a finished
// request waits in its response state until the register frees up
module bitmap_run_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [bra_pkg::ACT_W-1:0]  i_action,
    input  logic [bra_pkg::IDX_W-1:0]  i_index,
    input  logic [bra_pkg::CNT_W-1:0]  i_count,
    input  logic                       i_bit_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [bra_pkg::STAT_W-1:0] o_status,
    output logic [bra_pkg::IDX_W-1:0]  o_start_index,
    output logic                       o_bit_read,
    // config channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]  i_cfg_data
);
    import bra_pkg::*;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_bytes;
    logic [ACT_W-1:0]    r_action, n_action;
    logic [IDX_W-1:0]    r_index, n_index;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_setv, n_setv;       // value written by the modify pass
    logic [CNT_W-1:0]    r_lo, n_lo;           // modify range [lo, hi)
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [CNT_W-1:0]    r_run, n_run;         // free run carried across words
    logic [AW1-1:0]      r_rd_addr, n_rd_addr; // next word to read
    logic [AW1-1:0]      r_last, n_last;       // last word of the pass
    logic                r_pend, n_pend;       // read data of r_proc is valid
    logic [WA-1:0]       r_proc, n_proc;       // word whose data is in r_rdata
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_start, n_res_start;
    logic                r_res_bit, n_res_bit;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_start, n_out_start;
    logic                r_out_bit, n_out_bit;
    logic [WORDS-1:0]    r_vld;                // word holds written data, else reads zero

    // usage map ram
    logic [WORD_W-1:0]   r_mem [WORDS];
    logic [WORD_W-1:0]   r_rdata;
    logic                r_rd_vld;

    logic                in_xfer;
    logic                rd_en;
    logic [WA-1:0]       rd_addr;
    logic                wr_en;
    logic [WA-1:0]       wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                vld_clr;

    logic [CFG_W-1:0]    clamped;
    logic [CNT_W-1:0]    total;        // managed bit count
    logic [CNT_W-1:0]    words_total;
    logic [CNT_W-1:0]    base;         // bit position of r_proc bit 0
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   used;
    logic [CNT_W-1:0]    run_at [WORD_W];
    logic [WORD_W-1:0]   hit_vec;
    logic [WORD_SH-1:0]  hit_pos;
    logic [CNT_W-1:0]    acq_start;
    logic [CNT_W-1:0]    acq_end;
    logic [WORD_W-1:0]   mod_mask;
    logic [CNT_W-1:0]    rel_end;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_start_index = r_out_start;
    assign o_bit_read    = r_out_bit;

    // managed bits = min(bytes_in_use, MAP_BYTES) * 8
    assign clamped     = (32'(r_bytes) > 32'(MAP_BYTES)) ? CFG_W'(MAP_BYTES) : r_bytes;
    assign total       = CNT_W'(clamped) << 3;
    assign words_total = (total + CNT_W'(WORD_W - 1)) >> WORD_SH;

    // ------------------------------------------------------------------
    // ram port control
    // ------------------------------------------------------------------
    always_comb begin
        rd_en = 1'b0;
        unique case (r_state)
            S_SCAN, S_MOD: rd_en = (r_rd_addr <= r_last);
            S_CHK:         rd_en = !r_pend;
            default:       rd_en = 1'b0;
        endcase
    end
    assign rd_addr = r_rd_addr[WA-1:0];

    // unwritten words read as all free
    assign word = r_rd_vld ? r_rdata : '0;
    assign base = CNT_W'({r_proc, WORD_SH'(0)});

    // range mask of the modify pass for the current word
    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            mod_mask[k] = ((base + CNT_W'(k)) >= r_lo) && ((base + CNT_W'(k)) < r_hi);
        end
    end

    assign wr_en   = (r_state == S_MOD) && r_pend;
    assign wr_addr = r_proc;
    assign wr_data = r_setv ? (word | mod_mask) : (word & ~mod_mask);

    // ------------------------------------------------------------------
    // first-fit search over one word: the free run ending at each bit
    // is either the carried run plus the leading free bits, or the
    // distance to the nearest used bit at or below it
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            used[k] = word[k] || ((base + CNT_W'(k)) >= total);
        end
    end

    always_comb begin
        logic              any;
        logic [WORD_SH-1:0] last;
        for (int j = 0; j < WORD_W; j++) begin
            any  = 1'b0;
            last = '0;
            for (int k = 0; k < WORD_W; k++) begin
                if (k <= j && used[k]) begin
                    any  = 1'b1;
                    last = WORD_SH'(k);
                end
            end
            if (any) begin
                run_at[j] = CNT_W'(j) - CNT_W'(last);
            end else begin
                run_at[j] = r_run + CNT_W'(j + 1);
            end
            hit_vec[j] = (run_at[j] >= r_count);
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_pos = WORD_SH'(j);
            end
        end
    end

    assign acq_start = base + CNT_W'(hit_pos) + CNT_W'(1) - r_count;
    assign acq_end   = acq_start + r_count;
    assign rel_end   = CNT_W'(i_index) + i_count;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_index      = r_index;
        n_count      = r_count;
        n_setv       = r_setv;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_run        = r_run;
        n_rd_addr    = r_rd_addr;
        n_last       = r_last;
        n_pend       = 1'b0;
        n_proc       = r_proc;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_bit    = r_res_bit;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_bit    = r_out_bit;
        vld_clr      = 1'b0;

        if (rd_en) begin
            n_rd_addr = r_rd_addr + AW1'(1);
            n_proc    = rd_addr;
            n_pend    = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_action     = i_action;
                    n_index      = i_index;
                    n_count      = i_count;
                    n_setv       = i_bit_value;
                    n_res_status = ST_OK;
                    n_res_start  = '0;
                    n_res_bit    = 1'b0;
                    n_state      = S_RESP;
                    n_pend       = 1'b0;
                    case (i_action)
                        ACT_ACQUIRE: begin
                            if (i_count == '0 || i_count > total) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_run     = '0;
                                n_rd_addr = '0;
                                n_last    = AW1'(words_total - CNT_W'(1));
                                n_state   = S_SCAN;
                            end
                        end
                        ACT_RELEASE: begin
                            if (i_count == '0) begin
                                n_res_status = ST_OK;
                            end else if (CNT_W'(i_index) >= total
                                         || i_count > total - CNT_W'(i_index)) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_setv    = 1'b0;
                                n_lo      = CNT_W'(i_index);
                                n_hi      = rel_end;
                                n_rd_addr = AW1'(i_index >> WORD_SH);
                                n_last    = AW1'((rel_end - CNT_W'(1)) >> WORD_SH);
                                n_state   = S_MOD;
                            end
                        end
                        ACT_SET: begin
                            if (CNT_W'(i_index) >= total) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_lo      = CNT_W'(i_index);
                                n_hi      = CNT_W'(i_index) + CNT_W'(1);
                                n_rd_addr = AW1'(i_index >> WORD_SH);
                                n_last    = AW1'(i_index >> WORD_SH);
                                n_state   = S_MOD;
                            end
                        end
                        ACT_CHECK: begin
                            if (CNT_W'(i_index) >= total) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_rd_addr = AW1'(i_index >> WORD_SH);
                                n_state   = S_CHK;
                            end
                        end
                        ACT_CLEAR: begin
                            vld_clr = 1'b1;
                        end
                        default: begin
                            n_res_status = ST_RANGE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_pend) begin
                    n_run = run_at[WORD_W-1];
                    if (|hit_vec) begin
                        // found: mark the run used
                        n_res_start = acq_start[IDX_W-1:0];
                        n_setv      = 1'b1;
                        n_lo        = acq_start;
                        n_hi        = acq_end;
                        n_rd_addr   = AW1'(acq_start >> WORD_SH);
                        n_last      = AW1'((acq_end - CNT_W'(1)) >> WORD_SH);
                        n_pend      = 1'b0;
                        n_state     = S_MOD;
                    end else if (AW1'(r_proc) == r_last) begin
                        n_res_status = ST_NOSPACE;
                        n_pend       = 1'b0;
                        n_state      = S_RESP;
                    end
                end
            end

            S_MOD: begin
                if (r_pend && AW1'(r_proc) == r_last) begin
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                end
            end

            S_CHK: begin
                if (r_pend) begin
                    n_res_bit = word[r_index[WORD_SH-1:0]];
                    n_pend    = 1'b0;
                    n_state   = S_RESP;
                end
            end

            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_start  = r_res_start;
                    n_out_bit    = r_res_bit;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_bytes     <= BYTES_RESET;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (vld_clr) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_bytes <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_index      <= n_index;
        r_count      <= n_count;
        r_setv       <= n_setv;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_run        <= n_run;
        r_rd_addr    <= n_rd_addr;
        r_last       <= n_last;
        r_proc       <= n_proc;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_bit    <= n_res_bit;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
        r_out_bit    <= n_out_bit;
    end

    // usage map ram, one read and one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same map word in one cycle");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("request transfer did not leave idle");

    a_bit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bit_read) |-> (o_status == ST_OK))
        else $error("bit read reported with an error status");

    a_proc_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && (r_state == S_SCAN || r_state == S_MOD)) |-> (AW1'(r_proc) <= r_last))
        else $error("word processed beyond the end of the pass");

    a_action_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_action == ACT_ACQUIRE))
        else $error("scan running for a request other than acquire");

endmodule

// ===== verif/bitmap_alloc_checker.sv =====
module bitmap_alloc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [bra_pkg::ACT_W-1:0]  i_action,
    input  logic [bra_pkg::IDX_W-1:0]  i_index,
    input  logic [bra_pkg::CNT_W-1:0]  i_count,
    input  logic                       i_bit_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [bra_pkg::STAT_W-1:0] i_status,
    input  logic [bra_pkg::IDX_W-1:0]  i_start_index,
    input  logic                       i_bit_read,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]  i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import bra_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  start_index;
        logic              bit_read;
    } t_alloc_result;

    logic [MAP_BITS-1:0] usage_bits;
    logic [CFG_W-1:0]    managed_bytes;
    t_alloc_result       awaited_results[$];
    int                  fail_total = 0;

    // applies one request to the shadow map and returns its result
    function automatic t_alloc_result alloc_apply(input logic [ACT_W-1:0] act,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cnt,
                                                  input logic             val);
        t_alloc_result r;
        int unsigned   total;
        int unsigned   run;
        int unsigned   first;
        int unsigned   k;
        bit            found;
        r.status      = ST_OK;
        r.start_index = '0;
        r.bit_read    = 1'b0;
        total = ((managed_bytes > MAP_BYTES) ? MAP_BYTES : int'(managed_bytes)) * 8;
        case (act)
            ACT_ACQUIRE: begin
                if (cnt == 0 || cnt > total) begin
                    r.status = ST_RANGE;
                end else begin
                    run   = 0;
                    first = 0;
                    found = 1'b0;
                    // first fit: lowest run of cnt free bits
                    for (k = 0; k < total && !found; k++) begin
                        if (usage_bits[k])
                            run = 0;
                        else
                            run++;
                        if (run == cnt) begin
                            first = k + 1 - cnt;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        for (k = first; k < first + cnt; k++)
                            usage_bits[k] = 1'b1;
                        r.start_index = IDX_W'(first);
                    end
                end
            end
            ACT_RELEASE: begin
                if (cnt != 0) begin
                    if (idx >= total || cnt > total - idx) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (k = idx; k < idx + cnt; k++)
                            usage_bits[k] = 1'b0;
                    end
                end
            end
            ACT_SET: begin
                if (idx >= total)
                    r.status = ST_RANGE;
                else
                    usage_bits[idx] = val;
            end
            ACT_CHECK: begin
                if (idx >= total)
                    r.status = ST_RANGE;
                else
                    r.bit_read = usage_bits[idx];
            end
            ACT_CLEAR: begin
                usage_bits = '0;
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_alloc_result want;
        if (!i_rst_n) begin
            usage_bits    = '0;
            managed_bytes = BYTES_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                managed_bytes = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with none expected, status %0d start %0d bit %0d",
                             $time, i_status, i_start_index, i_bit_read);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_status);
                        fail_total++;
                    end
                    if (i_start_index !== want.start_index) begin
                        $display("%0t: start_index expected %0d actual %0d",
                                 $time, want.start_index, i_start_index);
                        fail_total++;
                    end
                    if (i_bit_read !== want.bit_read) begin
                        $display("%0t: bit_read expected %0d actual %0d",
                                 $time, want.bit_read, i_bit_read);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(alloc_apply(i_action, i_index, i_count,
                                                      i_bit_value));
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== verif/tb.sv =====
module tb;
    import bra_pkg::*;

    // clock and the one reset at the start
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [ACT_W-1:0]  in_action    = '0;
    logic [IDX_W-1:0]  in_index     = '0;
    logic [CNT_W-1:0]  in_count     = '0;
    logic              in_bit_value = 1'b0;

    // result channel
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [STAT_W-1:0] out_status;
    logic [IDX_W-1:0]  out_start_index;
    logic              out_bit_read;

    // config channel, bytes_in_use only
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data     = '0;

    int fail_count;
    int pending;

    // managed byte count as last written, used only to aim the stimulus
    int bytes_now = 128;

    // asks the receiver for its one long hold-off
    bit hold_request = 1'b0;

    always #2 clk = ~clk;

    bitmap_run_allocator dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (in_action),
        .i_index       (in_index),
        .i_count       (in_count),
        .i_bit_value   (in_bit_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (out_status),
        .o_start_index (out_start_index),
        .o_bit_read    (out_bit_read),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    bitmap_alloc_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_action      (in_action),
        .i_index       (in_index),
        .i_count       (in_count),
        .i_bit_value   (in_bit_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (out_status),
        .i_start_index (out_start_index),
        .i_bit_read    (out_bit_read),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // offer one request and hold it until the transfer; called at a rising edge,
    // returns at the edge of the transfer with valid still high
    // stall is looked at on the falling edge, where it is settled
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] cnt, input logic val);
        in_valid     <= 1'b1;
        in_action    <= act;
        in_index     <= idx;
        in_count     <= cnt;
        in_bit_value <= val;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    // wait until every predicted result has come back, end on a rising edge
    task automatic wait_drained;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // write bytes_in_use; only called while the block is idle
    task automatic write_bytes(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        bytes_now = v;
    endtask

    // receiver: stretches of random stall density, plus one long hold-off
    // while the sender keeps offering, so the block fills and stalls its input
    initial begin : receiver
        int stretch;
        int density;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                stretch = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: density = 0;
                    1: density = 30;
                    2: density = 70;
                    default: density = 95;
                endcase
                repeat (stretch) begin
                    out_stall <= ($urandom_range(0, 99) < density);
                    @(posedge clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [CFG_W-1:0] phase_bytes[10];
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        logic             val;
        int               total;
        int               lim;
        int               pick;
        int               burst_left;
        int               gap;

        // settings swept by the random part, extremes and clamping included
        phase_bytes = '{8'd128, 8'd4, 8'd17, 8'd1, 8'd64, 8'd200, 8'd0, 8'd2, 8'd255, 8'd96};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset setting of 128 bytes
        send_request(ACT_CHECK, 10'd0, 11'd0, 1'b0);        // fresh map reads free
        send_request(ACT_ACQUIRE, 10'd0, 11'd0, 1'b0);      // zero count
        send_request(ACT_ACQUIRE, 10'd0, 11'd1025, 1'b0);   // count beyond the map
        send_request(ACT_ACQUIRE, 10'd1023, 11'd2047, 1'b1);
        send_request(ACT_ACQUIRE, 10'd0, 11'd1024, 1'b0);   // whole map at once
        send_request(ACT_ACQUIRE, 10'd0, 11'd1, 1'b0);      // full, no space
        send_request(ACT_CHECK, 10'd1023, 11'd0, 1'b0);     // last bit used
        send_request(ACT_RELEASE, 10'd0, 11'd0, 1'b0);      // zero count release
        send_request(ACT_RELEASE, 10'd1000, 11'd100, 1'b0); // release past the end
        send_request(ACT_RELEASE, 10'd0, 11'd1024, 1'b0);   // free everything
        send_request(ACT_SET, 10'd5, 11'd0, 1'b1);
        send_request(ACT_SET, 10'd1023, 11'd2047, 1'b1);
        send_request(ACT_ACQUIRE, 10'd0, 11'd6, 1'b0);      // skips the used bit 5
        send_request(ACT_CHECK, 10'd6, 11'd0, 1'b0);
        send_request(ACT_SET, 10'd6, 11'd0, 1'b0);
        send_request(ACT_CHECK, 10'd6, 11'd0, 1'b0);
        send_request(3'd5, 10'd0, 11'd1, 1'b0);             // unknown actions
        send_request(3'd6, 10'd1, 11'd1, 1'b1);
        send_request(3'd7, 10'd1023, 11'd2047, 1'b1);
        send_request(ACT_CLEAR, 10'd0, 11'd0, 1'b0);
        send_request(ACT_CHECK, 10'd1023, 11'd0, 1'b0);
        in_valid <= 1'b0;
        wait_drained;

        // no managed bytes: acquire, set and check all out of range
        write_bytes(8'd0);
        send_request(ACT_ACQUIRE, 10'd0, 11'd1, 1'b0);
        send_request(ACT_SET, 10'd0, 11'd0, 1'b1);
        send_request(ACT_CHECK, 10'd0, 11'd0, 1'b0);
        in_valid <= 1'b0;
        wait_drained;

        // one byte: exactly 8 bits fit, then nothing
        write_bytes(8'd1);
        send_request(ACT_ACQUIRE, 10'd0, 11'd8, 1'b0);
        send_request(ACT_ACQUIRE, 10'd0, 11'd1, 1'b0);
        send_request(ACT_ACQUIRE, 10'd0, 11'd9, 1'b0);
        send_request(ACT_SET, 10'd8, 11'd0, 1'b1);
        in_valid <= 1'b0;
        wait_drained;

        // oversized setting clamps to the full map
        write_bytes(8'd255);
        send_request(ACT_CHECK, 10'd1023, 11'd0, 1'b0);
        in_valid <= 1'b0;
        wait_drained;

        // random part: phases of 95 requests, sender in bursts
        burst_left = $urandom_range(1, 20);
        foreach (phase_bytes[p]) begin
            write_bytes(phase_bytes[p]);
            total = ((bytes_now > MAP_BYTES) ? MAP_BYTES : bytes_now) * 8;
            if (p == 0)
                hold_request = 1'b1;
            repeat (95) begin
                act  = ACT_ACQUIRE;
                idx  = IDX_W'($urandom_range(0, 1023));
                cnt  = CNT_W'($urandom_range(0, 2047));
                val  = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 38) begin
                    // mostly small runs, now and then any count
                    if ($urandom_range(0, 9) != 0)
                        cnt = CNT_W'($urandom_range(1, 24));
                end else if (pick < 63) begin
                    act = ACT_RELEASE;
                    if (total > 0 && $urandom_range(0, 7) != 0) begin
                        idx = IDX_W'($urandom_range(0, total - 1));
                        lim = total - idx;
                        if (lim > 48)
                            lim = 48;
                        cnt = CNT_W'($urandom_range(0, lim));
                    end
                end else if (pick < 93) begin
                    act = (pick < 75) ? ACT_SET : ACT_CHECK;
                    if (total > 0 && $urandom_range(0, 7) != 0)
                        idx = IDX_W'($urandom_range(0, total - 1));
                end else if (pick < 96) begin
                    act = ACT_CLEAR;
                end else begin
                    act = ACT_W'($urandom_range(5, 7));
                end
                send_request(act, idx, cnt, val);
                burst_left--;
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 12);
                    if (gap > 0) begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 60);
                end
            end
            in_valid <= 1'b0;
            wait_drained;
        end

        // let the block settle past its longest request before the verdict
        repeat (100) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin : watchdog
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== bitmap_run_allocator.f =====
rtl/bra_pkg.sv
rtl/bitmap_run_allocator.sv
verif/bitmap_alloc_checker.sv
verif/tb.sv
